[rtl/core/graph_dfs_traversal_macros.svh]
// ----------------------------------------------------------------------------
// Graph DFS traversal assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DFS_TRAVERSAL_MACROS_SVH
`define GRAPH_DFS_TRAVERSAL_MACROS_SVH

// Invariant checked at every edge
`define GDFS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication
`define GDFS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define GDFS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gdfs_pkg.sv]
// ----------------------------------------------------------------------------
// gdfs_pkg
// Widths, codes and memory command types for the DFS traversal block.
// ----------------------------------------------------------------------------
package gdfs_pkg;

   localparam int VERT_W       = 6;
   localparam int VERT_SLOTS   = 64;
   localparam int MAX_VERTICES = 63;
   localparam int MAX_VISITS   = 63;
   localparam int ENTRY_SLOTS  = 256;
   localparam int ADDR_W       = $clog2(ENTRY_SLOTS);
   localparam int POS_W        = $clog2(ENTRY_SLOTS + 1);
   localparam int DEPTH_W      = $clog2(VERT_SLOTS);
   localparam int NODE_RESET   = 63;

   localparam logic [1:0] KIND_ADD_EDGE = 2'd0;
   localparam logic [1:0] KIND_TRAVERSE = 2'd1;
   localparam logic [1:0] KIND_CLEAR    = 2'd2;

   localparam logic [2:0] STATUS_VISIT      = 3'd0;
   localparam logic [2:0] STATUS_STORED     = 3'd1;
   localparam logic [2:0] STATUS_FULL       = 3'd2;
   localparam logic [2:0] STATUS_RANGE      = 3'd3;
   localparam logic [2:0] STATUS_CLEARED    = 3'd4;

   localparam logic [POS_W-1:0] NULL_POS = POS_W'(ENTRY_SLOTS);

   typedef struct packed {
      logic              clear;
      logic              head_rd_en;
      logic [VERT_W-1:0] head_rd_addr;
      logic              head_wr_en;
      logic [VERT_W-1:0] head_wr_addr;
      logic [POS_W-1:0]  head_wr_data;
      logic              ent_rd_en;
      logic [ADDR_W-1:0] ent_rd_addr;
      logic              ent_wr_en;
      logic [ADDR_W-1:0] ent_wr_addr;
      logic [VERT_W-1:0] ent_wr_target;
      logic [POS_W-1:0]  ent_wr_next;
   } adj_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]  head_pos;
      logic [VERT_W-1:0] ent_target;
      logic [POS_W-1:0]  ent_next;
   } adj_rsp_type;

endpackage

[rtl/core/graph_dfs_traversal.sv]
// ----------------------------------------------------------------------------
// graph_dfs_traversal
// Depth-first traversal over an undirected graph held as adjacency lists.
// ----------------------------------------------------------------------------
// Raise start for one cycle while busy is low to issue a command. Clear,
// rejected edges and rejected traversals answer with one result in the next
// cycle and leave busy low, so commands of those kinds may follow every cycle.
// An accepted edge holds busy through S_EDGE_A and S_EDGE_B and answers from
// a result registered in S_EDGE_B. A traversal reads the list head, entry and
// stack memories through registers: S_HEAD loads a vertex's list head, S_STEP
// reads the next entry, S_ENT visits or skips its target, and S_POP resumes
// the parent list once a deeper list is exhausted. Results come out one per
// strobe on rsp_valid and cannot be held off; the final result of each
// command has rsp_last set. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "graph_dfs_traversal_macros.svh"

module graph_dfs_traversal (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [gdfs_pkg::VERT_W-1:0] req_src_vertex,
   input  logic [gdfs_pkg::VERT_W-1:0] req_dst_vertex,
   output logic                        rsp_valid,
   output logic [gdfs_pkg::VERT_W-1:0] rsp_vertex,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [gdfs_pkg::VERT_W-1:0] csr_node_count
);
   import gdfs_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EDGE_A = 7'b0000010,
      S_EDGE_B = 7'b0000100,
      S_HEAD   = 7'b0001000,
      S_STEP   = 7'b0010000,
      S_ENT    = 7'b0100000,
      S_POP    = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [VERT_W-1:0]      node_count_ff;
   logic [POS_W-1:0]       entries_used_ff;
   logic [VERT_SLOTS-1:0]  visited_ff;
   logic [DEPTH_W-1:0]     depth_ff;
   logic [VERT_W-1:0]      count_ff;
   logic [VERT_W-1:0]      src_ff, dst_ff;
   logic [POS_W-1:0]       top_ff;
   logic [VERT_W-1:0]      pend_ff;
   logic [POS_W-1:0]       stack_mem [VERT_SLOTS];
   logic [POS_W-1:0]       stack_q_ff;

   logic                   rsp_valid_ff, rsp_last_ff;
   logic                   rsp_valid_in;
   logic [VERT_W-1:0]      rsp_vertex_ff;
   logic [2:0]             rsp_status_ff;

   adj_cmd_type            cmd;
   adj_rsp_type            adj;

   logic                   accept;
   logic [VERT_W-1:0]      active_count;
   logic                   src_ok, dst_ok, edge_room;
   logic                   top_null, take;
   logic [POS_W-1:0]       edge_next;
   logic [POS_W-1:0]       slot_hi;
   logic                   is_walk;

   gdfs_adj_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (adj)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      active_count = node_count_ff;
      if (node_count_ff == '0) begin
         active_count = VERT_W'(1);
      end else if (node_count_ff > VERT_W'(MAX_VERTICES)) begin
         active_count = VERT_W'(MAX_VERTICES);
      end
   end

   assign src_ok    = (req_src_vertex != '0) && (req_src_vertex <= active_count);
   assign dst_ok    = (req_dst_vertex != '0) && (req_dst_vertex <= active_count);
   assign edge_room = ({1'b0, entries_used_ff} + (POS_W+1)'(2)) <= (POS_W+1)'(ENTRY_SLOTS);

   assign top_null  = (top_ff >= NULL_POS);
   assign take      = !visited_ff[adj.ent_target] && (count_ff != VERT_W'(MAX_VISITS));
   assign slot_hi   = entries_used_ff + POS_W'(1);
   // self loop: the second entry follows the head just written for the first
   assign edge_next = (src_ff == dst_ff) ? entries_used_ff : adj.head_pos;
   assign is_walk   = (state_ff == S_HEAD) || (state_ff == S_STEP) ||
                      (state_ff == S_ENT) || (state_ff == S_POP);

   // memory commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.clear        = (req_kind == KIND_CLEAR);
               cmd.head_rd_en   = ((req_kind == KIND_ADD_EDGE) && src_ok && dst_ok &&
                                   edge_room) || ((req_kind == KIND_TRAVERSE) && src_ok);
               cmd.head_rd_addr = req_src_vertex;
            end
         end
         S_EDGE_A: begin
            cmd.ent_wr_en     = 1'b1;
            cmd.ent_wr_addr   = entries_used_ff[ADDR_W-1:0];
            cmd.ent_wr_target = dst_ff;
            cmd.ent_wr_next   = adj.head_pos;
            cmd.head_wr_en    = 1'b1;
            cmd.head_wr_addr  = src_ff;
            cmd.head_wr_data  = entries_used_ff;
            cmd.head_rd_en    = 1'b1;
            cmd.head_rd_addr  = dst_ff;
         end
         S_EDGE_B: begin
            cmd.ent_wr_en     = 1'b1;
            cmd.ent_wr_addr   = slot_hi[ADDR_W-1:0];
            cmd.ent_wr_target = src_ff;
            cmd.ent_wr_next   = edge_next;
            cmd.head_wr_en    = 1'b1;
            cmd.head_wr_addr  = dst_ff;
            cmd.head_wr_data  = slot_hi;
         end
         S_STEP: begin
            cmd.ent_rd_en   = !top_null;
            cmd.ent_rd_addr = top_ff[ADDR_W-1:0];
         end
         S_ENT: begin
            cmd.head_rd_en   = take;
            cmd.head_rd_addr = adj.ent_target;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind == KIND_ADD_EDGE) && src_ok && dst_ok && edge_room) begin
               state_in = S_EDGE_A;
            end else if (accept && (req_kind == KIND_TRAVERSE) && src_ok) begin
               state_in = S_HEAD;
            end
         end
         S_EDGE_A: state_in = S_EDGE_B;
         S_EDGE_B: state_in = S_IDLE;
         S_HEAD:   state_in = S_STEP;
         S_STEP: begin
            if (!top_null) begin
               state_in = S_ENT;
            end else if (depth_ff == DEPTH_W'(1)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_POP;
            end
         end
         S_ENT:    state_in = take ? S_HEAD : S_STEP;
         S_POP:    state_in = S_STEP;
         default:  state_in = S_IDLE;
      endcase
   end

   // result strobe
   always_comb begin
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_ADD_EDGE: rsp_valid_in = !(src_ok && dst_ok && edge_room);
                  KIND_TRAVERSE: rsp_valid_in = !src_ok;
                  KIND_CLEAR:    rsp_valid_in = 1'b1;
                  default:       rsp_valid_in = 1'b0;
               endcase
            end
         end
         S_EDGE_B: rsp_valid_in = 1'b1;
         S_STEP:   rsp_valid_in = top_null && (depth_ff == DEPTH_W'(1));
         S_ENT:    rsp_valid_in = take;
         default:  rsp_valid_in = 1'b0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         node_count_ff   <= VERT_W'(NODE_RESET);
         entries_used_ff <= '0;
         visited_ff      <= '0;
         depth_ff        <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if ((req_kind == KIND_TRAVERSE) && src_ok) begin
                     visited_ff <= VERT_SLOTS'(1) << req_src_vertex;
                     depth_ff   <= DEPTH_W'(1);
                     count_ff   <= VERT_W'(1);
                  end else if (req_kind == KIND_CLEAR) begin
                     entries_used_ff <= '0;
                     visited_ff      <= '0;
                     depth_ff        <= '0;
                  end
               end
            end
            S_EDGE_B: begin
               entries_used_ff <= entries_used_ff + POS_W'(2);
            end
            S_STEP: begin
               if (top_null) begin
                  depth_ff <= depth_ff - DEPTH_W'(1);
               end
            end
            S_ENT: begin
               if (take) begin
                  visited_ff[adj.ent_target] <= 1'b1;
                  depth_ff                   <= depth_ff + DEPTH_W'(1);
                  count_ff                   <= count_ff + VERT_W'(1);
               end
            end
            default: begin
               depth_ff <= depth_ff;
            end
         endcase
      end
   end

   // payload and stack memory
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            src_ff        <= req_src_vertex;
            dst_ff        <= req_dst_vertex;
            pend_ff       <= req_src_vertex;
            rsp_vertex_ff <= '0;
            rsp_last_ff   <= 1'b1;
            if (req_kind == KIND_CLEAR) begin
               rsp_status_ff <= STATUS_CLEARED;
            end else if (!(src_ok && dst_ok) || (req_kind == KIND_TRAVERSE)) begin
               rsp_status_ff <= STATUS_RANGE;
            end else begin
               rsp_status_ff <= STATUS_FULL;
            end
         end
         S_EDGE_B: begin
            rsp_vertex_ff <= '0;
            rsp_status_ff <= STATUS_STORED;
            rsp_last_ff   <= 1'b1;
         end
         S_HEAD: begin
            top_ff <= adj.head_pos;
         end
         S_STEP: begin
            // the final visit is held back until the walk runs dry
            rsp_vertex_ff <= pend_ff;
            rsp_status_ff <= STATUS_VISIT;
            rsp_last_ff   <= 1'b1;
            stack_q_ff    <= stack_mem[depth_ff - DEPTH_W'(2)];
         end
         S_ENT: begin
            top_ff        <= adj.ent_next;
            rsp_vertex_ff <= pend_ff;
            rsp_status_ff <= STATUS_VISIT;
            rsp_last_ff   <= 1'b0;
            if (take) begin
               stack_mem[depth_ff - DEPTH_W'(1)] <= adj.ent_next;
               pend_ff                           <= adj.ent_target;
            end
         end
         S_POP: begin
            top_ff <= stack_q_ff;
         end
         default: begin
            top_ff <= top_ff;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   `GDFS_ASSERT_IMP(a_single_not_visit, rsp_valid && (rsp_status != STATUS_VISIT),
                    rsp_last, "non-visit result without last")
   `GDFS_ASSERT_NXT(a_trav_goes_busy, accept && (req_kind == KIND_TRAVERSE) && src_ok,
                    busy && (state_ff == S_HEAD), "traversal did not start")
   `GDFS_ASSERT_IMP(a_walk_depth, is_walk, depth_ff != '0,
                    "walk running with empty stack")
   `GDFS_ASSERT_ALWAYS(a_entries_bound, entries_used_ff <= NULL_POS,
                       "entry count beyond capacity")

endmodule

[rtl/core/gdfs_adj_store.sv]
// ----------------------------------------------------------------------------
// gdfs_adj_store
// Adjacency store: list head memory with per-vertex valid bits, and the
// entry memory (target, next). Reads are registered.
// ----------------------------------------------------------------------------
module gdfs_adj_store (
   input  logic                 clock,
   input  logic                 reset,
   input  gdfs_pkg::adj_cmd_type cmd,
   output gdfs_pkg::adj_rsp_type rsp
);
   import gdfs_pkg::*;

   logic [POS_W-1:0]          head_mem [VERT_SLOTS];
   logic [VERT_W+POS_W-1:0]   ent_mem  [ENTRY_SLOTS];
   logic [VERT_SLOTS-1:0]     head_vld_ff;
   logic                      head_vld_q_ff;
   logic [POS_W-1:0]          head_q_ff;
   logic [VERT_W+POS_W-1:0]   ent_q_ff;

   // a head that was never written since the last clear reads as null
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         head_vld_ff <= '0;
      end else if (cmd.head_wr_en) begin
         head_vld_ff[cmd.head_wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.head_wr_en) begin
         head_mem[cmd.head_wr_addr] <= cmd.head_wr_data;
      end
      if (cmd.head_rd_en) begin
         head_q_ff     <= head_mem[cmd.head_rd_addr];
         head_vld_q_ff <= head_vld_ff[cmd.head_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ent_wr_en) begin
         ent_mem[cmd.ent_wr_addr] <= {cmd.ent_wr_target, cmd.ent_wr_next};
      end
      if (cmd.ent_rd_en) begin
         ent_q_ff <= ent_mem[cmd.ent_rd_addr];
      end
   end

   assign rsp.head_pos   = head_vld_q_ff ? head_q_ff : NULL_POS;
   assign rsp.ent_target = ent_q_ff[VERT_W+POS_W-1:POS_W];
   assign rsp.ent_next   = ent_q_ff[POS_W-1:0];

endmodule
